// File: rtl/core/bcr_pkg.sv
// ----------------------------------------------------------------------------
// bcr_pkg - shared types and constants of the bilinear crop resampler
// Widths of the fixed-point path, register codes and the command/status
// structs that connect the controller with the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bcr_pkg;

    // fixed-point layout
    localparam int RATIO_W    = 26;   // unsigned Q16 step ratio
    localparam int FRAC_W     = 16;   // fraction bits of ratio and position
    localparam int POS_W      = 35;   // ratio * dst + start, Q16
    localparam int XC_W       = 11;   // column coordinate inside the frame
    localparam int YC_W       = 10;   // row coordinate inside the frame
    localparam int CMP_W      = 13;   // frame bound compare (up to 4096)
    localparam int PATCH_W    = 11;   // patch size compare
    localparam int CH_W       = 8;    // one pixel channel
    localparam int NUM_CH     = 3;    // Y, U, V
    localparam int PIX_W      = CH_W * NUM_CH;
    localparam int WGT_W      = FRAC_W + 1;       // weight 0..65536
    localparam int H_W        = CH_W + WGT_W;     // horizontal blend
    localparam int S_W        = H_W + WGT_W;      // full Q32 sum
    localparam int Q88_W      = 16;               // Q8.8 result
    localparam int RND_POS    = 2 * FRAC_W - CH_W; // result LSB inside the sum

    // ratio divider
    localparam int DIV_STEPS  = RATIO_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int DEN_W      = 9;
    localparam int CROP_W     = 10;

    // limits
    localparam int MAX_PATCH  = 256;

    localparam logic [WGT_W-1:0] Q_ONE     = WGT_W'(1 << FRAC_W);
    localparam logic [S_W-1:0]   ROUND_BIT = S_W'(1) << (RND_POS - 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CROP_LEFT   = 3'd0,
        REG_CROP_TOP    = 3'd1,
        REG_CROP_WIDTH  = 3'd2,
        REG_CROP_HEIGHT = 3'd3,
        REG_OUT_WIDTH   = 3'd4,
        REG_OUT_HEIGHT  = 3'd5
    } bcr_reg_t;

    // register reset values
    localparam logic [9:0] RST_CROP_LEFT   = 10'd0;
    localparam logic [8:0] RST_CROP_TOP    = 9'd0;
    localparam logic [9:0] RST_CROP_WIDTH  = 10'd640;
    localparam logic [8:0] RST_CROP_HEIGHT = 9'd480;
    localparam logic [8:0] RST_OUT_WIDTH   = 9'd32;
    localparam logic [8:0] RST_OUT_HEIGHT  = 9'd32;

    // op codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic       op;
        logic [9:0] src_col;
        logic [8:0] src_row;
        logic [7:0] src_luma;
        logic [7:0] src_cb;
        logic [7:0] src_cr;
        logic [7:0] dst_col;
        logic [7:0] dst_row;
    } bcr_item_t;

    typedef struct packed {
        logic [15:0] luma_q8;
        logic [15:0] cb_q8;
        logic [15:0] cr_q8;
        logic        range_error;
    } bcr_result_t;

    // controller -> datapath
    typedef struct packed {
        logic cap;        // capture accepted word
        logic wr;         // store pixel
        logic map;        // position and range check
        logic coord;      // neighbor coordinates and weights
        logic base;       // row base addresses
        logic rd_top;     // read upper neighbor pair
        logic rd_bot;     // read lower neighbor pair
        logic hblend;     // horizontal blend
        logic load;       // vertical blend into result register
        logic div_start;  // start ratio divide
        logic div_sel;    // 0 column ratio, 1 row ratio
    } bcr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_op;
        logic div_busy;
    } bcr_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/bcr_if.sv
// ----------------------------------------------------------------------------
// bcr_if - channel interfaces of the bilinear crop resampler
// Item, result and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcr_item_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [9:0] src_col;
    logic [8:0] src_row;
    logic [7:0] src_luma;
    logic [7:0] src_cb;
    logic [7:0] src_cr;
    logic [7:0] dst_col;
    logic [7:0] dst_row;

    modport source (
        output valid, op, src_col, src_row, src_luma, src_cb, src_cr, dst_col, dst_row,
        input  ready
    );
    modport sink (
        input  valid, op, src_col, src_row, src_luma, src_cb, src_cr, dst_col, dst_row,
        output ready
    );
endinterface

interface bcr_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] luma_q8;
    logic [15:0] cb_q8;
    logic [15:0] cr_q8;
    logic        range_error;

    modport source (
        output valid, luma_q8, cb_q8, cr_q8, range_error,
        input  ready
    );
    modport sink (
        input  valid, luma_q8, cb_q8, cr_q8, range_error,
        output ready
    );
endinterface

interface bcr_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/bcr_ctrl.sv
// ----------------------------------------------------------------------------
// bcr_ctrl - sequencer of the bilinear crop resampler
// Runs the ratio divides after reset and configuration writes, then steps
// each accepted word through the store write or the sample pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_fire,
    input  bcr_pkg::bcr_sts_t sts,
    output bcr_pkg::bcr_cmd_t cmd
);
    import bcr_pkg::*;

    typedef enum logic [3:0] {
        S_DIVX_GO,
        S_DIVX_RUN,
        S_DIVY_GO,
        S_DIVY_RUN,
        S_IDLE,
        S_WRITE,
        S_MAP,
        S_COORD,
        S_BASE,
        S_RD_TOP,
        S_RD_BOT,
        S_HBLEND,
        S_VBLEND
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;
    logic   redo_reg, redo_next;
    logic   accept;
    logic   pend;
    logic   load_now;

    assign accept   = in_ready_reg & item_valid;
    assign pend     = cfg_fire | redo_reg;
    assign load_now = (state_reg == S_VBLEND) & (~out_valid_reg | out_ready);

    // command decode
    always_comb
    begin
        cmd           = '0;
        cmd.cap       = accept;
        cmd.load      = load_now;
        case (state_reg)
            S_DIVX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b0;
            end
            S_DIVY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
            end
            S_WRITE:  cmd.wr     = 1'b1;
            S_MAP:    cmd.map    = 1'b1;
            S_COORD:  cmd.coord  = 1'b1;
            S_BASE:   cmd.base   = 1'b1;
            S_RD_TOP: cmd.rd_top = 1'b1;
            S_RD_BOT: cmd.rd_bot = 1'b1;
            S_HBLEND: cmd.hblend = 1'b1;
            default:  ;
        endcase
    end

    // next state; a config write reruns both divides once the block is free
    always_comb
    begin
        state_next = state_reg;
        redo_next  = redo_reg;
        case (state_reg)
            S_DIVX_GO:
            begin
                redo_next = 1'b0;
                // a register landing with the start restarts on the new value
                if (cfg_fire)
                    state_next = S_DIVX_GO;
                else
                    state_next = S_DIVX_RUN;
            end
            S_DIVX_RUN:
            begin
                if (cfg_fire)
                    state_next = S_DIVX_GO;
                else if (!sts.div_busy)
                    state_next = S_DIVY_GO;
            end
            S_DIVY_GO:
            begin
                if (cfg_fire)
                    state_next = S_DIVX_GO;
                else
                    state_next = S_DIVY_RUN;
            end
            S_DIVY_RUN:
            begin
                if (cfg_fire)
                    state_next = S_DIVX_GO;
                else if (!sts.div_busy)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    redo_next  = pend;
                    state_next = (sts.item_op == OP_SAMPLE) ? S_MAP : S_WRITE;
                end
                else if (pend)
                begin
                    state_next = S_DIVX_GO;
                end
            end
            S_WRITE:  state_next = pend ? S_DIVX_GO : S_IDLE;
            S_MAP:
            begin
                redo_next  = pend;
                state_next = S_COORD;
            end
            S_COORD:
            begin
                redo_next  = pend;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                redo_next  = pend;
                state_next = S_RD_TOP;
            end
            S_RD_TOP:
            begin
                redo_next  = pend;
                state_next = S_RD_BOT;
            end
            S_RD_BOT:
            begin
                redo_next  = pend;
                state_next = S_HBLEND;
            end
            S_HBLEND:
            begin
                redo_next  = pend;
                state_next = S_VBLEND;
            end
            S_VBLEND:
            begin
                redo_next = pend;
                if (load_now)
                    state_next = pend ? S_DIVX_GO : S_IDLE;
            end
            default:  state_next = S_DIVX_GO;
        endcase
    end

    // registered handshake outputs
    always_comb
    begin
        in_ready_next  = (state_next == S_IDLE);
        out_valid_next = load_now | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_DIVX_GO;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            redo_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
            redo_reg      <= redo_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/bcr_dpath.sv
// ----------------------------------------------------------------------------
// bcr_dpath - datapath of the bilinear crop resampler
// Config registers, bit-serial ratio divider, frame store with two read
// ports, position mapping and the two-step separable bilinear blend.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_dpath #(
    parameter int FRAME_COLS = 640,
    parameter int FRAME_ROWS = 480
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bcr_pkg::bcr_cmd_t                  cmd,
    output bcr_pkg::bcr_sts_t                  sts,
    input  bcr_pkg::bcr_item_t                 item_word,
    input  logic                               cfg_fire,
    input  logic [bcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bcr_pkg::bcr_result_t               result_word
);
    import bcr_pkg::*;

    localparam int DEPTH  = FRAME_COLS * FRAME_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XR_W   = POS_W - FRAC_W;

    // ---------------- configuration registers ----------------
    logic [9:0] crop_left_reg;
    logic [8:0] crop_top_reg;
    logic [9:0] crop_width_reg;
    logic [8:0] crop_height_reg;
    logic [8:0] out_width_reg;
    logic [8:0] out_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crop_left_reg   <= RST_CROP_LEFT;
            crop_top_reg    <= RST_CROP_TOP;
            crop_width_reg  <= RST_CROP_WIDTH;
            crop_height_reg <= RST_CROP_HEIGHT;
            out_width_reg   <= RST_OUT_WIDTH;
            out_height_reg  <= RST_OUT_HEIGHT;
        end
        else if (cfg_fire)
        begin
            case (bcr_reg_t'(cfg_index))
                REG_CROP_LEFT:   crop_left_reg   <= cfg_data[9:0];
                REG_CROP_TOP:    crop_top_reg    <= cfg_data[8:0];
                REG_CROP_WIDTH:  crop_width_reg  <= cfg_data[9:0];
                REG_CROP_HEIGHT: crop_height_reg <= cfg_data[8:0];
                REG_OUT_WIDTH:   out_width_reg   <= cfg_data[8:0];
                REG_OUT_HEIGHT:  out_height_reg  <= cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    // ---------------- ratio divider, one quotient bit a cycle ----------------
    logic [RATIO_W-1:0]   col_ratio_reg, row_ratio_reg;
    logic [RATIO_W-1:0]   div_q_reg;
    logic [DEN_W-1:0]     div_rem_reg;
    logic [DEN_W-1:0]     div_den_reg;
    logic                 div_sel_reg;
    logic                 div_busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [CROP_W-1:0]    div_crop;
    logic [DEN_W-1:0]     div_outn;
    logic                 div_special;
    logic [RATIO_W-1:0]   div_num;
    logic [DEN_W-1:0]     div_den;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;
    logic                 fits;
    logic [RATIO_W-1:0]   q_new;

    always_comb
    begin
        div_crop    = cmd.div_sel ? {1'b0, crop_height_reg} : crop_width_reg;
        div_outn    = cmd.div_sel ? out_height_reg : out_width_reg;
        // output size of zero or one, or empty crop: ratio is zero (0 / 1)
        div_special = (div_outn <= DEN_W'(1)) | (div_crop == '0);
        div_num     = div_special ? '0 : {div_crop - CROP_W'(1), {FRAC_W{1'b0}}};
        div_den     = div_special ? DEN_W'(1) : div_outn - DEN_W'(1);
        rem_sh      = {div_rem_reg, div_q_reg[RATIO_W-1]};
        rem_sub     = rem_sh - {1'b0, div_den_reg};
        fits        = (rem_sh >= {1'b0, div_den_reg});
        q_new       = {div_q_reg[RATIO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            if (div_cnt_reg == DIV_CNT_W'(1))
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_q_reg   <= div_num;
            div_rem_reg <= '0;
            div_den_reg <= div_den;
            div_sel_reg <= cmd.div_sel;
        end
        else if (div_busy_reg)
        begin
            div_q_reg   <= q_new;
            div_rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            if (div_cnt_reg == DIV_CNT_W'(1))
            begin
                if (div_sel_reg)
                    row_ratio_reg <= q_new;
                else
                    col_ratio_reg <= q_new;
            end
        end
    end

    assign sts.div_busy = div_busy_reg;
    assign sts.item_op  = item_word.op;

    // ---------------- accepted word ----------------
    bcr_item_t cap_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
            cap_reg <= item_word;
    end

    // ---------------- frame store ----------------
    logic [PIX_W-1:0]  mem [DEPTH];
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_in_frame;
    logic [PIX_W-1:0]  wr_pix;
    logic [ADDR_W-1:0] base_l_reg, base_h_reg;
    logic [XC_W-1:0]   xl_reg, xh_reg;
    logic [YC_W-1:0]   yl_reg, yh_reg;
    logic [ADDR_W-1:0] rd_base;
    logic [ADDR_W-1:0] rd_addr0, rd_addr1;
    logic [PIX_W-1:0]  rd0_reg, rd1_reg;
    logic [PIX_W-1:0]  top0_reg, top1_reg;

    always_comb
    begin
        wr_in_frame = (CMP_W'(cap_reg.src_col) < CMP_W'(FRAME_COLS)) &
                      (CMP_W'(cap_reg.src_row) < CMP_W'(FRAME_ROWS));
        wr_addr     = ADDR_W'(cap_reg.src_row) * ADDR_W'(FRAME_COLS) +
                      ADDR_W'(cap_reg.src_col);
        wr_pix      = {cap_reg.src_luma, cap_reg.src_cb, cap_reg.src_cr};
        rd_base     = cmd.rd_bot ? base_h_reg : base_l_reg;
        rd_addr0    = rd_base + ADDR_W'(xl_reg);
        rd_addr1    = rd_base + ADDR_W'(xh_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr && wr_in_frame)
            mem[wr_addr] <= wr_pix;
        if (cmd.rd_top || cmd.rd_bot)
        begin
            rd0_reg <= mem[rd_addr0];
            rd1_reg <= mem[rd_addr1];
        end
    end

    // upper pair parks here while the lower pair is read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_bot)
        begin
            top0_reg <= rd0_reg;
            top1_reg <= rd1_reg;
        end
    end

    // ---------------- position mapping and range check ----------------
    logic [RATIO_W+7:0] col_prod, row_prod;
    logic [POS_W-1:0]   px_next, py_next;
    logic [POS_W-1:0]   px_reg, py_reg;
    logic               bad_next, bad_reg;
    logic [XC_W-1:0]    xmax_reg;
    logic [YC_W-1:0]    ymax_reg;

    always_comb
    begin
        col_prod = (RATIO_W+8)'(col_ratio_reg) * (RATIO_W+8)'(cap_reg.dst_col);
        row_prod = (RATIO_W+8)'(row_ratio_reg) * (RATIO_W+8)'(cap_reg.dst_row);
        px_next  = POS_W'(col_prod) + (POS_W'(crop_left_reg) << FRAC_W);
        py_next  = POS_W'(row_prod) + (POS_W'(crop_top_reg) << FRAC_W);
        bad_next = ({1'b0, cap_reg.dst_col} >= out_width_reg) |
                   ({1'b0, cap_reg.dst_row} >= out_height_reg) |
                   (PATCH_W'(out_width_reg) > PATCH_W'(MAX_PATCH)) |
                   (PATCH_W'(out_height_reg) > PATCH_W'(MAX_PATCH)) |
                   (crop_width_reg == '0) | (crop_height_reg == '0) |
                   (CMP_W'(crop_left_reg) + CMP_W'(crop_width_reg) > CMP_W'(FRAME_COLS)) |
                   (CMP_W'(crop_top_reg) + CMP_W'(crop_height_reg) > CMP_W'(FRAME_ROWS));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            bad_reg  <= bad_next;
            xmax_reg <= XC_W'(crop_left_reg) + XC_W'(crop_width_reg) - XC_W'(1);
            ymax_reg <= YC_W'(crop_top_reg) + YC_W'(crop_height_reg) - YC_W'(1);
        end
    end

    // ---------------- neighbor coordinates, clamped to the crop edge ----------------
    logic [XR_W-1:0]   xl_raw, yl_raw;
    logic [XC_W-1:0]   xl_c;
    logic [YC_W-1:0]   yl_c;
    logic [XC_W:0]     xl_inc;
    logic [YC_W:0]     yl_inc;
    logic [FRAC_W-1:0] fx_reg, fy_reg;

    always_comb
    begin
        xl_raw = px_reg[POS_W-1:FRAC_W];
        yl_raw = py_reg[POS_W-1:FRAC_W];
        xl_c   = (xl_raw > XR_W'(xmax_reg)) ? xmax_reg : xl_raw[XC_W-1:0];
        yl_c   = (yl_raw > XR_W'(ymax_reg)) ? ymax_reg : yl_raw[YC_W-1:0];
        xl_inc = (XC_W+1)'(xl_c) + (XC_W+1)'(1);
        yl_inc = (YC_W+1)'(yl_c) + (YC_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coord)
        begin
            xl_reg <= xl_c;
            yl_reg <= yl_c;
            xh_reg <= (xl_inc < (XC_W+1)'(xmax_reg)) ? xl_inc[XC_W-1:0] : xmax_reg;
            yh_reg <= (yl_inc < (YC_W+1)'(ymax_reg)) ? yl_inc[YC_W-1:0] : ymax_reg;
            fx_reg <= px_reg[FRAC_W-1:0];
            fy_reg <= py_reg[FRAC_W-1:0];
        end
    end

    // row base addresses
    always_ff @(posedge clk)
    begin
        if (cmd.base)
        begin
            base_l_reg <= ADDR_W'(yl_reg) * ADDR_W'(FRAME_COLS);
            base_h_reg <= ADDR_W'(yh_reg) * ADDR_W'(FRAME_COLS);
        end
    end

    // ---------------- horizontal blend: p0 * (1 - fx) + p1 * fx ----------------
    logic [WGT_W-1:0] wx0, wx1, wy0, wy1;
    logic [H_W-1:0]   h_top_next [NUM_CH];
    logic [H_W-1:0]   h_bot_next [NUM_CH];
    logic [H_W-1:0]   h_top_reg  [NUM_CH];
    logic [H_W-1:0]   h_bot_reg  [NUM_CH];

    always_comb
    begin
        wx1 = WGT_W'(fx_reg);
        wx0 = Q_ONE - wx1;
        wy1 = WGT_W'(fy_reg);
        wy0 = Q_ONE - wy1;
        for (int k = 0; k < NUM_CH; k++)
        begin
            h_top_next[k] = H_W'(top0_reg[PIX_W-1-CH_W*k -: CH_W]) * H_W'(wx0) +
                            H_W'(top1_reg[PIX_W-1-CH_W*k -: CH_W]) * H_W'(wx1);
            h_bot_next[k] = H_W'(rd0_reg[PIX_W-1-CH_W*k -: CH_W]) * H_W'(wx0) +
                            H_W'(rd1_reg[PIX_W-1-CH_W*k -: CH_W]) * H_W'(wx1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hblend)
        begin
            for (int k = 0; k < NUM_CH; k++)
            begin
                h_top_reg[k] <= h_top_next[k];
                h_bot_reg[k] <= h_bot_next[k];
            end
        end
    end

    // ---------------- vertical blend and Q8.8 rounding ----------------
    logic [S_W-1:0]   vsum [NUM_CH];
    logic [Q88_W-1:0] chan_q8 [NUM_CH];

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            vsum[k]    = S_W'(h_top_reg[k]) * S_W'(wy0) +
                         S_W'(h_bot_reg[k]) * S_W'(wy1) + ROUND_BIT;
            chan_q8[k] = vsum[k][RND_POS +: Q88_W];
        end
    end

    bcr_result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (bad_reg)
            begin
                result_reg.luma_q8     <= '0;
                result_reg.cb_q8       <= '0;
                result_reg.cr_q8       <= '0;
                result_reg.range_error <= 1'b1;
            end
            else
            begin
                result_reg.luma_q8     <= chan_q8[0];
                result_reg.cb_q8       <= chan_q8[1];
                result_reg.cr_q8       <= chan_q8[2];
                result_reg.range_error <= 1'b0;
            end
        end
    end

    assign result_word = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/bilinear_crop_resampler_core.sv
// ----------------------------------------------------------------------------
// bilinear_crop_resampler_core - crop window bilinear resampler, top level
// Frame store of YUV pixels plus a resampler that maps an output patch
// position into a crop window and blends four neighbors into Q8.8.
// ----------------------------------------------------------------------------
// A pixel write word is accepted and then written to the frame store; a sample
// word passes from accept to the result register through map, clamp, row address,
// two reads of the two-port frame store, horizontal and vertical blend, and
// the next word is taken while the result waits on the result channel. After
// reset and after every configuration write the column and row Q16 ratios
// are rebuilt by one shared bit-serial divider, 26 steps per ratio, and no
// word is accepted while they are rebuilt. Configuration writes are always
// taken. A sample that reads a store entry never written returns undefined
// channel values.
`default_nettype none

module bilinear_crop_resampler_core #(
    parameter int FRAME_COLS = 640,
    parameter int FRAME_ROWS = 480
) (
    input  logic                clk,
    input  logic                rst_n,
    bcr_item_if.sink            item,
    bcr_result_if.source        result,
    bcr_cfg_if.sink             cfg
);
    import bcr_pkg::*;

    bcr_cmd_t    cmd;
    bcr_sts_t    sts;
    bcr_item_t   item_word;
    bcr_result_t result_word;
    logic        in_ready;
    logic        out_valid;
    logic        cfg_fire;

    // channel unpacking
    assign item_word = '{
        op:       item.op,
        src_col:  item.src_col,
        src_row:  item.src_row,
        src_luma: item.src_luma,
        src_cb:   item.src_cb,
        src_cr:   item.src_cr,
        dst_col:  item.dst_col,
        dst_row:  item.dst_row
    };

    assign item.ready         = in_ready;
    assign result.valid       = out_valid;
    assign result.luma_q8     = result_word.luma_q8;
    assign result.cb_q8       = result_word.cb_q8;
    assign result.cr_q8       = result_word.cr_q8;
    assign result.range_error = result_word.range_error;

    // config words are always taken
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid & cfg.ready;

    bcr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (result.ready),
        .cfg_fire   (cfg_fire),
        .sts        (sts),
        .cmd        (cmd)
    );

    bcr_dpath #(
        .FRAME_COLS (FRAME_COLS),
        .FRAME_ROWS (FRAME_ROWS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .item_word   (item_word),
        .cfg_fire    (cfg_fire),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .result_word (result_word)
    );

endmodule

`default_nettype wire
